// ----- hw/rtl/tape_machine_interpreter_defines.svh -----
// Assertion macros shared by the tape machine interpreter RTL.
`ifndef TAPE_MACHINE_INTERPRETER_DEFINES_SVH
`define TAPE_MACHINE_INTERPRETER_DEFINES_SVH

`ifndef SYNTH
// Property that must hold at every clock edge outside reset.
`define TMI_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);
// Consequent must hold in the same cycle as the antecedent.
`define TMI_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// Consequent must hold in the cycle after the antecedent.
`define TMI_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define TMI_ASSERT(name, prop, msg)
`define TMI_ASSERT_IMPL(name, ante, cons, msg)
`define TMI_ASSERT_NEXT(name, ante, cons, msg)
`endif

`endif

// ----- hw/rtl/tmi_pkg.sv -----
// Types, constants and decode helpers shared by the tape machine interpreter.
package tmi_pkg;

  // Default sizes of the stores and the cell.
  localparam int unsigned PROG_DEPTH_DEF = 4096;
  localparam int unsigned TAPE_DEPTH_DEF = 4096;
  localparam int unsigned CELL_BITS_DEF  = 8;

  // Field widths of the stream items.
  localparam int unsigned OPCODE_W     = 2;
  localparam int unsigned ADDR_W       = 12;
  localparam int unsigned BYTE_W       = 8;
  localparam int unsigned STATUS_W     = 2;
  localparam int unsigned S_TDATA_W    = 24;
  localparam int unsigned S_TUSER_W    = OPCODE_W;
  localparam int unsigned OUT_FIELDS_W = STATUS_W + 1 + BYTE_W + 1 + BYTE_W;
  localparam int unsigned M_TDATA_W    = 24;

  // Item kinds carried in tuser.
  typedef enum logic [1:0] {
    OP_LOAD    = 2'd0,
    OP_STEP    = 2'd1,
    OP_RESTART = 2'd2,
    OP_NOP     = 2'd3
  } op_e;

  // Result status, also used as the sticky halt code (ST_RUN while running).
  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_RUN     = 2'd1,
    ST_END     = 2'd2,
    ST_BRACKET = 2'd3
  } status_e;

  // Program characters.
  localparam logic [7:0] CH_ZERO  = 8'h00;
  localparam logic [7:0] CH_RIGHT = 8'h3E;
  localparam logic [7:0] CH_LEFT  = 8'h3C;
  localparam logic [7:0] CH_INC   = 8'h2B;
  localparam logic [7:0] CH_DEC   = 8'h2D;
  localparam logic [7:0] CH_OUT   = 8'h2E;
  localparam logic [7:0] CH_IN    = 8'h2C;
  localparam logic [7:0] CH_OPEN  = 8'h5B;
  localparam logic [7:0] CH_CLOSE = 8'h5D;

  // Decoded class of a program byte.
  typedef enum logic [3:0] {
    CLS_ZERO,
    CLS_RIGHT,
    CLS_LEFT,
    CLS_INC,
    CLS_DEC,
    CLS_OUT,
    CLS_IN,
    CLS_OPEN,
    CLS_CLOSE,
    CLS_OTHER
  } cls_e;

  // Controller states.
  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_CLEAR,
    S_EXEC,
    S_TREAD,
    S_TLOAD,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_RESP
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic restart;
    logic clr_step;
    logic exec;
    logic halt_end;
    logic scan_start;
    logic scan_rd;
    logic scan_chk;
    logic scan_fail;
    logic tape_load;
    logic out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    op_e  opcode;
    logic halted;
    logic pp_end;
    cls_e pcls;
    logic cell_zero;
    logic scan_fail_rd;
    logic scan_fail_chk;
    logic scan_match;
    logic clr_done;
    logic out_free;
  } sts_t;

  // Map a program byte to its command class.
  function automatic cls_e cls_of(input logic [7:0] c);
    cls_e r;
    case (c)
      CH_ZERO:  r = CLS_ZERO;
      CH_RIGHT: r = CLS_RIGHT;
      CH_LEFT:  r = CLS_LEFT;
      CH_INC:   r = CLS_INC;
      CH_DEC:   r = CLS_DEC;
      CH_OUT:   r = CLS_OUT;
      CH_IN:    r = CLS_IN;
      CH_OPEN:  r = CLS_OPEN;
      CH_CLOSE: r = CLS_CLOSE;
      default:  r = CLS_OTHER;
    endcase
    return r;
  endfunction

endpackage

// ----- hw/rtl/tmi_ctrl.sv -----
// Controller state machine of the tape machine interpreter.
`include "tape_machine_interpreter_defines.svh"

module tmi_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  tmi_pkg::sts_t sts_i,
  output tmi_pkg::cmd_t cmd_o
);
  import tmi_pkg::*;

  state_e state_q, state_d;

  // State register; reset starts the tape clearing sweep.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_INIT: begin
        if (sts_i.clr_done) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          case (sts_i.opcode)
            OP_RESTART: state_d = S_CLEAR;
            OP_STEP:    state_d = sts_i.halted ? S_RESP : S_EXEC;
            default:    state_d = S_RESP;
          endcase
        end
      end
      S_CLEAR: begin
        if (sts_i.clr_done) state_d = S_RESP;
      end
      S_EXEC: begin
        if (sts_i.pp_end) begin
          state_d = S_RESP;
        end else begin
          case (sts_i.pcls)
            CLS_RIGHT, CLS_LEFT: state_d = S_TREAD;
            CLS_OPEN:  state_d = sts_i.cell_zero ? S_SCAN_RD : S_RESP;
            CLS_CLOSE: state_d = sts_i.cell_zero ? S_RESP : S_SCAN_RD;
            default:   state_d = S_RESP;
          endcase
        end
      end
      S_TREAD: state_d = S_TLOAD;
      S_TLOAD: state_d = S_RESP;
      S_SCAN_RD: begin
        state_d = sts_i.scan_fail_rd ? S_RESP : S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        if (sts_i.scan_fail_chk || sts_i.scan_match) state_d = S_RESP;
        else state_d = S_SCAN_RD;
      end
      S_RESP: begin
        if (sts_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_INIT;
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_INIT: cmd_o.clr_step = 1'b1;
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept  = 1'b1;
          cmd_o.restart = (sts_i.opcode == OP_RESTART);
        end
      end
      S_CLEAR: cmd_o.clr_step = 1'b1;
      S_EXEC: begin
        if (sts_i.pp_end || sts_i.pcls == CLS_ZERO) begin
          cmd_o.halt_end = 1'b1;
        end else if ((sts_i.pcls == CLS_OPEN && sts_i.cell_zero) ||
                     (sts_i.pcls == CLS_CLOSE && !sts_i.cell_zero)) begin
          cmd_o.scan_start = 1'b1;
        end else begin
          cmd_o.exec = 1'b1;
        end
      end
      S_TREAD: ;
      S_TLOAD: cmd_o.tape_load = 1'b1;
      S_SCAN_RD: begin
        if (sts_i.scan_fail_rd) cmd_o.scan_fail = 1'b1;
        else cmd_o.scan_rd = 1'b1;
      end
      S_SCAN_CHK: begin
        if (sts_i.scan_fail_chk) cmd_o.scan_fail = 1'b1;
        else cmd_o.scan_chk = 1'b1;
      end
      S_RESP: cmd_o.out_load = sts_i.out_free;
      default: ;
    endcase
  end

  // At most one datapath operation per cycle.
  `TMI_ASSERT(a_one_op, $onehot0({cmd_o.accept, cmd_o.clr_step, cmd_o.exec, cmd_o.halt_end, cmd_o.scan_start, cmd_o.scan_rd, cmd_o.scan_chk, cmd_o.scan_fail, cmd_o.tape_load, cmd_o.out_load}), "more than one datapath operation")
  // A result is never written over one still waiting.
  `TMI_ASSERT_IMPL(a_no_overrun, cmd_o.out_load, sts_i.out_free, "result overrun")
  // A step taken while halted answers at once.
  `TMI_ASSERT_NEXT(a_halted_step, cmd_o.accept && sts_i.opcode == OP_STEP && sts_i.halted, state_q == S_RESP, "halted step did not answer directly")

endmodule

// ----- hw/rtl/tmi_dpath.sv -----
// Datapath of the tape machine interpreter: stores, pointers and result register.
`include "tape_machine_interpreter_defines.svh"

module tmi_dpath #(
  parameter int unsigned PROG_DEPTH = tmi_pkg::PROG_DEPTH_DEF,
  parameter int unsigned TAPE_DEPTH = tmi_pkg::TAPE_DEPTH_DEF,
  parameter int unsigned CELL_BITS  = tmi_pkg::CELL_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [tmi_pkg::S_TDATA_W-1:0]  in_data_i,
  input  logic [tmi_pkg::S_TUSER_W-1:0]  in_user_i,
  input  tmi_pkg::cmd_t                  cmd_i,
  output tmi_pkg::sts_t                  sts_o,
  input  logic                           out_ready_i,
  output logic                           out_valid_o,
  output logic [tmi_pkg::M_TDATA_W-1:0]  out_data_o
);
  import tmi_pkg::*;

  localparam int unsigned PAW = $clog2(PROG_DEPTH);
  localparam int unsigned PPW = PAW + 1;
  localparam int unsigned TAW = $clog2(TAPE_DEPTH);
  localparam logic [PPW-1:0] PP_END  = PPW'(PROG_DEPTH);
  localparam logic [TAW-1:0] DP_LAST = TAW'(TAPE_DEPTH - 1);

  // Input item fields.
  logic [ADDR_W-1:0] in_addr;
  logic [BYTE_W-1:0] in_byte;
  op_e               in_op;

  assign in_addr = in_data_i[ADDR_W-1:0];
  assign in_byte = in_data_i[ADDR_W +: BYTE_W];
  assign in_op   = op_e'(in_user_i);

  // Stores.
  logic [7:0]           prog_mem [PROG_DEPTH];
  logic [7:0]           prog_rdata_q;
  logic                 prog_we;
  logic [PAW-1:0]       prog_waddr;
  logic [PAW-1:0]       prog_raddr;
  logic [CELL_BITS-1:0] tape_mem [TAPE_DEPTH];
  logic [CELL_BITS-1:0] tape_rdata_q;
  logic                 tape_we;
  logic [TAW-1:0]       tape_waddr;
  logic [CELL_BITS-1:0] tape_wdata;

  // Machine state.
  logic [PPW-1:0]       pp_q;
  logic [TAW-1:0]       dp_q;
  status_e              halt_q;
  logic [CELL_BITS-1:0] cell_q;
  logic [TAW-1:0]       clr_cnt_q;
  logic [PPW-1:0]       scan_a_q;
  logic [PPW-1:0]       depth_q;
  logic                 scan_back_q;
  logic                 out_valid_q;

  // Item payload and result fields.
  logic [BYTE_W-1:0]    byte_q;
  status_e              res_st_q;
  logic                 res_ov_q;
  logic [BYTE_W-1:0]    res_ob_q;
  logic                 res_it_q;
  logic [M_TDATA_W-1:0] out_data_q;

  cls_e                 pcls;
  logic [PPW-1:0]       scan_next;
  logic                 scan_match;
  logic                 clr_done;
  logic                 cell_write;
  logic [CELL_BITS-1:0] cell_new;
  logic [TAW-1:0]       dp_new;

  // Decode of the fetched program byte.
  assign pcls = cls_of(prog_rdata_q);

  // Bracket scan walk.
  assign scan_next  = scan_back_q ? (scan_a_q - PPW'(1)) : (scan_a_q + PPW'(1));
  assign scan_match = (depth_q == PPW'(1)) &&
                      (scan_back_q ? (pcls == CLS_OPEN) : (pcls == CLS_CLOSE));
  assign clr_done   = (clr_cnt_q == DP_LAST);

  // Cell and data pointer update of one command.
  always_comb begin
    cell_new   = cell_q;
    dp_new     = dp_q;
    cell_write = 1'b0;
    case (pcls)
      CLS_INC: begin
        cell_new   = cell_q + CELL_BITS'(1);
        cell_write = 1'b1;
      end
      CLS_DEC: begin
        cell_new   = cell_q - CELL_BITS'(1);
        cell_write = 1'b1;
      end
      CLS_IN: begin
        cell_new   = CELL_BITS'(byte_q);
        cell_write = 1'b1;
      end
      CLS_RIGHT: dp_new = (dp_q == DP_LAST) ? '0 : (dp_q + TAW'(1));
      CLS_LEFT:  dp_new = (dp_q == '0) ? DP_LAST : (dp_q - TAW'(1));
      default: ;
    endcase
  end

  // Store ports.
  assign prog_we    = cmd_i.accept && (in_op == OP_LOAD) && (32'(in_addr) < PROG_DEPTH);
  assign prog_waddr = PAW'(in_addr);
  assign prog_raddr = cmd_i.scan_rd ? PAW'(scan_next) : PAW'(pp_q);
  assign tape_we    = cmd_i.clr_step || (cmd_i.exec && cell_write);
  assign tape_waddr = cmd_i.clr_step ? clr_cnt_q : dp_q;
  assign tape_wdata = cmd_i.clr_step ? '0 : cell_new;

  // Program store with registered read.
  always_ff @(posedge clk_i) begin
    if (prog_we) prog_mem[prog_waddr] <= in_byte;
    prog_rdata_q <= prog_mem[prog_raddr];
  end

  // Tape store with registered read at the data pointer.
  always_ff @(posedge clk_i) begin
    if (tape_we) tape_mem[tape_waddr] <= tape_wdata;
    tape_rdata_q <= tape_mem[dp_q];
  end

  // Pointers, halt code, cached current cell and scan state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pp_q        <= '0;
      dp_q        <= '0;
      halt_q      <= ST_RUN;
      cell_q      <= '0;
      clr_cnt_q   <= '0;
      scan_a_q    <= '0;
      depth_q     <= '0;
      scan_back_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.restart) begin
        pp_q      <= '0;
        dp_q      <= '0;
        halt_q    <= ST_RUN;
        cell_q    <= '0;
        clr_cnt_q <= '0;
      end
      if (cmd_i.clr_step) begin
        clr_cnt_q <= clr_done ? '0 : (clr_cnt_q + TAW'(1));
      end
      if (cmd_i.exec) begin
        pp_q   <= pp_q + PPW'(1);
        dp_q   <= dp_new;
        cell_q <= cell_new;
      end
      if (cmd_i.halt_end) halt_q <= ST_END;
      if (cmd_i.scan_fail) halt_q <= ST_BRACKET;
      if (cmd_i.scan_start) begin
        scan_a_q    <= pp_q;
        depth_q     <= PPW'(1);
        scan_back_q <= (pcls == CLS_CLOSE);
      end
      if (cmd_i.scan_rd) scan_a_q <= scan_next;
      if (cmd_i.scan_chk) begin
        if (scan_match) begin
          pp_q <= scan_a_q + PPW'(1);
        end else if ((pcls == CLS_OPEN && !scan_back_q) ||
                     (pcls == CLS_CLOSE && scan_back_q)) begin
          depth_q <= depth_q + PPW'(1);
        end else if (pcls == CLS_OPEN || pcls == CLS_CLOSE) begin
          depth_q <= depth_q - PPW'(1);
        end
      end
      if (cmd_i.tape_load) cell_q <= tape_rdata_q;
      if (cmd_i.out_load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  // Result fields of the item at work and the output register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      byte_q   <= in_byte;
      res_st_q <= (in_op == OP_STEP) ? halt_q : ST_DONE;
      res_ov_q <= 1'b0;
      res_ob_q <= '0;
      res_it_q <= 1'b0;
    end
    if (cmd_i.exec && pcls == CLS_OUT) begin
      res_ov_q <= 1'b1;
      res_ob_q <= cell_q[BYTE_W-1:0];
    end
    if (cmd_i.exec && pcls == CLS_IN) res_it_q <= 1'b1;
    if (cmd_i.halt_end) res_st_q <= ST_END;
    if (cmd_i.scan_fail) res_st_q <= ST_BRACKET;
    if (cmd_i.out_load) begin
      out_data_q <= {{(M_TDATA_W - OUT_FIELDS_W){1'b0}}, cell_q[BYTE_W-1:0], res_it_q,
                     res_ob_q, res_ov_q, res_st_q};
    end
  end

  // Status to the controller.
  always_comb begin
    sts_o.opcode        = in_op;
    sts_o.halted        = (halt_q != ST_RUN);
    sts_o.pp_end        = (pp_q == PP_END);
    sts_o.pcls          = pcls;
    sts_o.cell_zero     = (cell_q == '0);
    sts_o.scan_fail_rd  = scan_back_q ? (scan_a_q == '0) : (scan_next == PP_END);
    sts_o.scan_fail_chk = !scan_back_q && (pcls == CLS_ZERO);
    sts_o.scan_match    = scan_match;
    sts_o.clr_done      = clr_done;
    sts_o.out_free      = !out_valid_q || out_ready_i;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // The data pointer stays inside the tape store; the program pointer goes at most one past its store.
  `TMI_ASSERT(a_dp_range, 32'(dp_q) < TAPE_DEPTH, "data pointer out of range")
  `TMI_ASSERT(a_pp_range, 32'(pp_q) <= PROG_DEPTH, "program pointer out of range")
  // Only a restart leaves a halted state.
  `TMI_ASSERT_NEXT(a_halt_sticky, halt_q != ST_RUN && !cmd_i.restart, halt_q == $past(halt_q), "halt code changed without restart")
  // An open scan always has an unmatched bracket.
  `TMI_ASSERT_IMPL(a_scan_depth, cmd_i.scan_chk, depth_q != '0, "scan depth reached zero")

endmodule

// ----- hw/rtl/tape_machine_interpreter.sv -----
// Top level of the tape machine interpreter: controller plus datapath.
//
// Input items arrive on the s_axis channel. tuser holds the item kind:
// load a program byte, execute one step, restart, or no operation. Every
// item gives exactly one result item on the m_axis channel.
// A load or no-operation item goes straight to its result once taken; a
// plain step reads the program store, then executes. The moves '>' and
// '<' then read the new cell from the tape store through its registered
// port. A bracket scan makes, for each program byte it walks over, one
// program store read and then one check.
// A restart clears the tape one cell a cycle, then answers. After reset
// the same clearing pass runs with s_axis_tready low. The program store
// is not cleared and must be loaded before it is run.
// Items are worked on one at a time. The result sits in an output register;
// the next item is taken while it waits, and that item's result waits in
// turn until the receiver takes the first one (m_axis_tready high).
module tape_machine_interpreter #(
  parameter int unsigned PROG_DEPTH = tmi_pkg::PROG_DEPTH_DEF,
  parameter int unsigned TAPE_DEPTH = tmi_pkg::TAPE_DEPTH_DEF,
  parameter int unsigned CELL_BITS  = tmi_pkg::CELL_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // prog_addr[11:0], data_byte[19:12], zeros above
  input  logic [tmi_pkg::S_TDATA_W-1:0] s_axis_tdata,
  // opcode[1:0]
  input  logic [tmi_pkg::S_TUSER_W-1:0] s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // status[1:0], out_valid[2], out_byte[10:3], input_taken[11],
  // cell_value[19:12], zeros above
  output logic [tmi_pkg::M_TDATA_W-1:0] m_axis_tdata
);
  import tmi_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequencer.
  tmi_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Stores, pointers and result register.
  tmi_dpath #(
    .PROG_DEPTH (PROG_DEPTH),
    .TAPE_DEPTH (TAPE_DEPTH),
    .CELL_BITS  (CELL_BITS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (s_axis_tdata),
    .in_user_i   (s_axis_tuser),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (m_axis_tdata)
  );

endmodule
